// ===== rtl/scdm_pkg.sv =====
package scdm_pkg;

    localparam int LINE_LEN  = 20;
    localparam int POS_W     = $clog2(LINE_LEN);
    localparam int REPLY_LEN = 5;
    localparam int IDX_W     = $clog2(REPLY_LEN);

    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [7:0] DEADBAND_RST = 8'd10;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_QM   = 8'h3F;
    localparam logic [7:0] CH_S    = 8'h73;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_Y    = 8'h79;

    typedef struct packed {
        logic             capture;
        logic             step;
        logic             load;
        logic [IDX_W-1:0] idx;
    } dp_ctl_t;

    typedef struct packed {
        logic status_req;
    } dp_stat_t;

endpackage

// ===== rtl/serial_command_dual_motor_pwm.sv =====
// Serial command decoder for two PWM motor axes. Each request carries either a
// received serial byte or a bare limit switch sample. Lines are parsed as the
// bytes arrive (no line buffer), and "!x?hh" / "!y?hh" set an axis speed of
// 2*hh-255. Every request yields one result with the four compare values;
// a "!s" line yields five, carrying the reply "!s?<hex digit>\n" one byte each.
// The first result passes through the parse step and then the output load in the
// controller sequence; further reply bytes follow one per cycle while m_tready
// is high. A new request is taken once the last result of the previous one is
// loaded into the output register, so the block does not take a new request
// before it is through with the last one. The deadband register resets to 10.
module serial_command_dual_motor_pwm (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte[7:0], limit_switches[11:8], zero[15:12]
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // x_forward_compare[7:0], x_reverse_compare[15:8],
                                   // y_forward_compare[23:16], y_reverse_compare[31:24],
                                   // tx_byte[39:32]
    output logic        m_tuser,   // tx_valid
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    scdm_pkg::dp_ctl_t  dp_ctl;
    scdm_pkg::dp_stat_t dp_stat;

    assign cfg_ready = 1'b1;

    scdm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (dp_stat),
        .ctl      (dp_ctl)
    );

    scdm_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (dp_ctl),
        .stat     (dp_stat),
        .in_op    (s_tuser),
        .in_byte  (s_tdata[7:0]),
        .in_sw    (s_tdata[11:8]),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .out_data (m_tdata),
        .out_user (m_tuser),
        .out_last (m_tlast)
    );

    a_step_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        dp_ctl.step |-> $past(s_tvalid && s_tready))
        else $error("parse step without a captured request");

    a_plain_result_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata[39:32] == 8'h00)))
        else $error("plain result not single or carries a reply byte");

    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[7:0] == 8'h00 || m_tdata[15:8] == 8'h00) &&
                      (m_tdata[23:16] == 8'h00 || m_tdata[31:24] == 8'h00)))
        else $error("axis driven in both directions");

endmodule

// ===== rtl/scdm_ctrl.sv =====
module scdm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  scdm_pkg::dp_stat_t stat,
    output scdm_pkg::dp_ctl_t  ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_LOAD,
        S_SEND
    } state_t;

    state_t                       state_reg;
    logic                         valid_reg;
    logic                         valid_next;
    logic [scdm_pkg::IDX_W-1:0]   idx_reg;
    logic                         out_free;

    assign out_free = !valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;

    always_comb
    begin
        ctl.capture = s_tvalid && (state_reg == S_IDLE);
        ctl.step    = (state_reg == S_STEP);
        ctl.load    = ((state_reg == S_LOAD) && out_free) ||
                      ((state_reg == S_SEND) && m_tready);
        ctl.idx     = idx_reg;
        if (ctl.load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= S_STEP;
                    end
                end
                S_STEP:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    if (out_free)
                    begin
                        if (stat.status_req)
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_SEND;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_SEND:
                begin
                    if (m_tready)
                    begin
                        if (idx_reg == scdm_pkg::IDX_W'(scdm_pkg::REPLY_LEN - 1))
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/scdm_dp.sv =====
module scdm_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  scdm_pkg::dp_ctl_t  ctl,
    output scdm_pkg::dp_stat_t stat,
    input  logic               in_op,
    input  logic [7:0]         in_byte,
    input  logic [3:0]         in_sw,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data,
    output logic [39:0]        out_data,
    output logic               out_user,
    output logic               out_last
);

    // returns {ok, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // returns {reverse, forward}
    function automatic logic [15:0] drive(input logic signed [8:0] s, input logic plus_on,
                                          input logic minus_on, input logic [7:0] db);
        logic       neg;
        logic [7:0] mag;
        logic       act;
        neg = s[8];
        mag = neg ? 8'(-s) : s[7:0];
        act = (mag > db) && !(neg ? minus_on : plus_on);
        return {(act && neg) ? ~s[7:0] : 8'h00, (act && !neg) ? mag : 8'h00};
    endfunction

    logic                        op_reg;
    logic [7:0]                  byte_reg;
    logic [3:0]                  sw_reg;
    logic [scdm_pkg::POS_W-1:0]  wp_reg;
    logic                        bang_reg;
    logic [7:0]                  cmd_reg;
    logic                        qm_reg;
    logic                        tok_reg;
    logic                        sec_reg;
    logic                        d1ok_reg;
    logic [3:0]                  d1_reg;
    logic                        d2ok_reg;
    logic [3:0]                  d2_reg;
    logic [7:0]                  hex_reg;
    logic signed [8:0]           x_speed_reg;
    logic signed [8:0]           y_speed_reg;
    logic                        status_reg;
    logic [7:0]                  deadband_reg;
    logic [39:0]                 data_reg;
    logic                        user_reg;
    logic                        last_reg;

    logic                        end_line;
    logic                        axis_ok;
    logic [7:0]                  hex_next;
    logic signed [9:0]           speed_wide;
    logic [4:0]                  hv;
    logic [3:0]                  inv;
    logic [15:0]                 x_drv;
    logic [15:0]                 y_drv;
    logic [7:0]                  tx_byte;

    assign stat.status_req = status_reg;
    assign out_data        = data_reg;
    assign out_user        = user_reg;
    assign out_last        = last_reg;

    always_comb
    begin
        end_line = (byte_reg == scdm_pkg::CH_LF) || (byte_reg == scdm_pkg::CH_NUL) ||
                   (wp_reg >= scdm_pkg::POS_W'(scdm_pkg::LINE_LEN - 1));
        axis_ok  = bang_reg && qm_reg && tok_reg &&
                   ((cmd_reg == scdm_pkg::CH_X) || (cmd_reg == scdm_pkg::CH_Y));
        if (d1ok_reg)
        begin
            hex_next = d2ok_reg ? {d1_reg, d2_reg} : {4'h0, d1_reg};
        end
        else
        begin
            hex_next = hex_reg;
        end
        speed_wide = $signed({1'b0, hex_next, 1'b0}) - 10'sd255;
        hv         = hex_val(byte_reg);
        inv        = ~sw_reg;
        x_drv      = drive(x_speed_reg, inv[0], inv[1], deadband_reg);
        y_drv      = drive(y_speed_reg, inv[2], inv[3], deadband_reg);
        case (ctl.idx)
            3'd0:    tx_byte = scdm_pkg::CH_BANG;
            3'd1:    tx_byte = scdm_pkg::CH_S;
            3'd2:    tx_byte = scdm_pkg::CH_QM;
            3'd3:    tx_byte = (inv <= 4'd9) ? (8'h30 + {4'h0, inv}) : (8'h57 + {4'h0, inv});
            default: tx_byte = scdm_pkg::CH_LF;
        endcase
        if (!status_reg)
        begin
            tx_byte = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            bang_reg     <= 1'b0;
            cmd_reg      <= 8'h00;
            qm_reg       <= 1'b0;
            tok_reg      <= 1'b0;
            sec_reg      <= 1'b0;
            d1ok_reg     <= 1'b0;
            d1_reg       <= 4'h0;
            d2ok_reg     <= 1'b0;
            d2_reg       <= 4'h0;
            hex_reg      <= 8'h00;
            x_speed_reg  <= '0;
            y_speed_reg  <= '0;
            status_reg   <= 1'b0;
            deadband_reg <= scdm_pkg::DEADBAND_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                deadband_reg <= cfg_data;
            end
            if (ctl.step)
            begin
                // "!s" alone or "!s?..." both ask for status
                status_reg <= (op_reg == scdm_pkg::OP_BYTE) && end_line && bang_reg &&
                              (cmd_reg == scdm_pkg::CH_S) &&
                              (qm_reg || (wp_reg == scdm_pkg::POS_W'(2)));
                if (op_reg == scdm_pkg::OP_BYTE)
                begin
                    if (end_line)
                    begin
                        if (axis_ok)
                        begin
                            hex_reg <= hex_next;
                            if (cmd_reg == scdm_pkg::CH_X)
                            begin
                                x_speed_reg <= speed_wide[8:0];
                            end
                            else
                            begin
                                y_speed_reg <= speed_wide[8:0];
                            end
                        end
                        wp_reg   <= '0;
                        bang_reg <= 1'b0;
                        cmd_reg  <= 8'h00;
                        qm_reg   <= 1'b0;
                        tok_reg  <= 1'b0;
                        sec_reg  <= 1'b0;
                        d1ok_reg <= 1'b0;
                        d2ok_reg <= 1'b0;
                    end
                    else
                    begin
                        wp_reg <= wp_reg + 1'b1;
                        if (wp_reg == scdm_pkg::POS_W'(0))
                        begin
                            bang_reg <= (byte_reg == scdm_pkg::CH_BANG);
                        end
                        else if (wp_reg == scdm_pkg::POS_W'(1))
                        begin
                            cmd_reg <= byte_reg;
                        end
                        else if (wp_reg == scdm_pkg::POS_W'(2))
                        begin
                            qm_reg <= (byte_reg == scdm_pkg::CH_QM);
                        end
                        else if (!tok_reg)
                        begin
                            if (byte_reg != scdm_pkg::CH_QM)
                            begin
                                tok_reg  <= 1'b1;
                                sec_reg  <= 1'b1;
                                d1ok_reg <= hv[4];
                                d1_reg   <= hv[3:0];
                            end
                        end
                        else if (sec_reg)
                        begin
                            sec_reg  <= 1'b0;
                            d2ok_reg <= hv[4];
                            d2_reg   <= hv[3:0];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_reg   <= in_op;
            byte_reg <= in_byte;
            sw_reg   <= in_sw;
        end
        if (ctl.load)
        begin
            data_reg <= {tx_byte, y_drv[15:8], y_drv[7:0], x_drv[15:8], x_drv[7:0]};
            user_reg <= status_reg;
            last_reg <= !status_reg ||
                        (ctl.idx == scdm_pkg::IDX_W'(scdm_pkg::REPLY_LEN - 1));
        end
    end

endmodule
